// ===== design/fgw_pkg.sv =====
// Shared types and constants for the face gradient wall correction pipeline.
// No dependencies; imported by every module of the block.
package fgw_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int NUM_W         = 96;   // widest dividend: 2^63 * 2^31
   localparam int DEN_W         = 64;
   localparam int QUO_W         = 41;   // quotient clamps at 2^40
   localparam int DIV_LAT       = QUO_W + 1;
   localparam int TERM_W        = QUO_W + 1;
   localparam int SUM_W         = TERM_W + 2;

   localparam logic [QUO_W-1:0] CLAMP_MAG = {1'b1, {(QUO_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_INTERIOR = 2'd0,
      KIND_WALL     = 2'd1,
      KIND_OTHER    = 2'd2,
      KIND_SPARE    = 2'd3
   } face_kind_type;

   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_DEGEN = 1'b1;

   // per-item data that rides alongside the dividers
   typedef struct packed {
      logic                     wall_ok;
      logic                     status;
      logic signed [DATA_W-1:0] res_x;
      logic signed [DATA_W-1:0] res_y;
      logic signed [DATA_W-1:0] g_x;
      logic signed [DATA_W-1:0] g_y;
      logic                     neg1_x;
      logic                     neg1_y;
      logic                     neg2_x;
      logic                     neg2_y;
   } fgw_side_type;

endpackage

// ===== design/fgw_front.sv =====
// Front end: products, dot products, magnitudes and dividend assembly (5 stages).
// Depends on fgw_pkg.
module fgw_front import fgw_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [1:0]         in_kind,
   input  logic [10*DATA_W-1:0] in_data,
   output logic               out_valid,
   output logic [NUM_W-1:0]   num1_x,
   output logic [NUM_W-1:0]   num1_y,
   output logic [NUM_W-1:0]   num2_x,
   output logic [NUM_W-1:0]   num2_y,
   output logic [DEN_W-1:0]   den_d,
   output logic [DEN_W-1:0]   den_l,
   output fgw_side_type       out_side
);

   logic signed [DATA_W-1:0] ax, ay, bx, by, nx, ny, ox, oy, wv, cv;
   face_kind_type            kind;
   logic signed [DATA_W:0]   sum_x, sum_y, dlt;

   assign kind = face_kind_type'(in_kind);
   assign ax = $signed(in_data[0*DATA_W +: DATA_W]);
   assign ay = $signed(in_data[1*DATA_W +: DATA_W]);
   assign bx = $signed(in_data[2*DATA_W +: DATA_W]);
   assign by = $signed(in_data[3*DATA_W +: DATA_W]);
   assign nx = $signed(in_data[4*DATA_W +: DATA_W]);
   assign ny = $signed(in_data[5*DATA_W +: DATA_W]);
   assign ox = $signed(in_data[6*DATA_W +: DATA_W]);
   assign oy = $signed(in_data[7*DATA_W +: DATA_W]);
   assign wv = $signed(in_data[8*DATA_W +: DATA_W]);
   assign cv = $signed(in_data[9*DATA_W +: DATA_W]);

   assign sum_x = {ax[DATA_W-1], ax} + {bx[DATA_W-1], bx};
   assign sum_y = {ay[DATA_W-1], ay} + {by[DATA_W-1], by};
   assign dlt   = {wv[DATA_W-1], wv} - {cv[DATA_W-1], cv};

   // stage 1: raw products
   logic                       v1_ff;
   logic signed [2*DATA_W-1:0] p_nox_ff, p_noy_ff, p_gnx_ff, p_gny_ff, p_nnx_ff, p_nny_ff;
   logic [DATA_W:0]            dmag_dlt_ff;
   logic                       dneg_dlt_ff;
   logic [DATA_W-1:0]          nm_x1_ff, nm_y1_ff;
   logic                       nn_x1_ff, nn_y1_ff, wall1_ff;
   logic signed [DATA_W-1:0]   rx1_ff, ry1_ff, gx1_ff, gy1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p_nox_ff    <= nx * ox;
         p_noy_ff    <= ny * oy;
         p_gnx_ff    <= ax * nx;
         p_gny_ff    <= ay * ny;
         p_nnx_ff    <= nx * nx;
         p_nny_ff    <= ny * ny;
         dneg_dlt_ff <= dlt[DATA_W];
         dmag_dlt_ff <= dlt[DATA_W] ? (DATA_W+1)'(-dlt) : dlt;
         nm_x1_ff    <= nx[DATA_W-1] ? DATA_W'(-nx) : nx;
         nm_y1_ff    <= ny[DATA_W-1] ? DATA_W'(-ny) : ny;
         nn_x1_ff    <= nx[DATA_W-1];
         nn_y1_ff    <= ny[DATA_W-1];
         wall1_ff    <= (kind == KIND_WALL);
         rx1_ff      <= (kind == KIND_INTERIOR) ? sum_x[DATA_W:1] : '0;
         ry1_ff      <= (kind == KIND_INTERIOR) ? sum_y[DATA_W:1] : '0;
         gx1_ff      <= ax;
         gy1_ff      <= ay;
      end
   end

   // stage 2: dot products and delta * |n|
   logic                     v2_ff;
   logic signed [2*DATA_W:0] d2_ff, g2_ff, l2_ff;
   logic [DEN_W-1:0]         m1_x2_ff, m1_y2_ff;
   logic                     dneg_dlt2_ff, nn_x2_ff, nn_y2_ff, wall2_ff;
   logic [DATA_W-1:0]        nm_x2_ff, nm_y2_ff;
   logic signed [DATA_W-1:0] rx2_ff, ry2_ff, gx2_ff, gy2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_ff        <= {p_nox_ff[2*DATA_W-1], p_nox_ff} + {p_noy_ff[2*DATA_W-1], p_noy_ff};
         g2_ff        <= {p_gnx_ff[2*DATA_W-1], p_gnx_ff} + {p_gny_ff[2*DATA_W-1], p_gny_ff};
         l2_ff        <= {p_nnx_ff[2*DATA_W-1], p_nnx_ff} + {p_nny_ff[2*DATA_W-1], p_nny_ff};
         m1_x2_ff     <= DEN_W'(dmag_dlt_ff * nm_x1_ff);
         m1_y2_ff     <= DEN_W'(dmag_dlt_ff * nm_y1_ff);
         dneg_dlt2_ff <= dneg_dlt_ff;
         nn_x2_ff     <= nn_x1_ff;
         nn_y2_ff     <= nn_y1_ff;
         nm_x2_ff     <= nm_x1_ff;
         nm_y2_ff     <= nm_y1_ff;
         wall2_ff     <= wall1_ff;
         rx2_ff       <= rx1_ff;
         ry2_ff       <= ry1_ff;
         gx2_ff       <= gx1_ff;
         gy2_ff       <= gy1_ff;
      end
   end

   // stage 3: magnitudes, signs, degenerate check
   logic              v3_ff;
   logic [DEN_W-1:0]  dmag3_ff, gmag3_ff, l3_ff;
   logic [NUM_W-1:0]  n1_x3_ff, n1_y3_ff;
   logic [DATA_W-1:0] nm_x3_ff, nm_y3_ff;
   fgw_side_type      side3_in, side3_ff;
   logic              deg3;

   assign deg3 = wall2_ff && ((l2_ff == '0) || (d2_ff == '0));

   always_comb begin
      side3_in.wall_ok = wall2_ff && !deg3;
      side3_in.status  = deg3 ? STAT_DEGEN : STAT_OK;
      side3_in.res_x   = rx2_ff;
      side3_in.res_y   = ry2_ff;
      side3_in.g_x     = gx2_ff;
      side3_in.g_y     = gy2_ff;
      side3_in.neg1_x  = d2_ff[2*DATA_W] ^ dneg_dlt2_ff ^ nn_x2_ff;
      side3_in.neg1_y  = d2_ff[2*DATA_W] ^ dneg_dlt2_ff ^ nn_y2_ff;
      side3_in.neg2_x  = g2_ff[2*DATA_W] ^ nn_x2_ff;
      side3_in.neg2_y  = g2_ff[2*DATA_W] ^ nn_y2_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dmag3_ff <= d2_ff[2*DATA_W] ? DEN_W'(-d2_ff) : d2_ff[DEN_W-1:0];
         gmag3_ff <= g2_ff[2*DATA_W] ? DEN_W'(-g2_ff) : g2_ff[DEN_W-1:0];
         l3_ff    <= l2_ff[DEN_W-1:0];
         n1_x3_ff <= NUM_W'(m1_x2_ff) << FRAC_BITS;
         n1_y3_ff <= NUM_W'(m1_y2_ff) << FRAC_BITS;
         nm_x3_ff <= nm_x2_ff;
         nm_y3_ff <= nm_y2_ff;
         side3_ff <= side3_in;
      end
   end

   // stage 4: |G| * |n| as two 32x32 partials
   logic                v4_ff;
   logic [2*DATA_W-1:0] lo_x4_ff, hi_x4_ff, lo_y4_ff, hi_y4_ff;
   logic [DEN_W-1:0]    dmag4_ff, l4_ff;
   logic [NUM_W-1:0]    n1_x4_ff, n1_y4_ff;
   fgw_side_type        side4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_x4_ff <= gmag3_ff[DATA_W-1:0] * nm_x3_ff;
         hi_x4_ff <= gmag3_ff[DEN_W-1:DATA_W] * nm_x3_ff;
         lo_y4_ff <= gmag3_ff[DATA_W-1:0] * nm_y3_ff;
         hi_y4_ff <= gmag3_ff[DEN_W-1:DATA_W] * nm_y3_ff;
         dmag4_ff <= dmag3_ff;
         l4_ff    <= l3_ff;
         n1_x4_ff <= n1_x3_ff;
         n1_y4_ff <= n1_y3_ff;
         side4_ff <= side3_ff;
      end
   end

   // stage 5: combine partials into the second dividend
   logic [NUM_W-1:0] n1_x5_ff, n1_y5_ff, n2_x5_ff, n2_y5_ff;
   logic [DEN_W-1:0] dmag5_ff, l5_ff;
   logic             v5_ff;
   fgw_side_type     side5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         n2_x5_ff <= {hi_x4_ff, {DATA_W{1'b0}}} + NUM_W'(lo_x4_ff);
         n2_y5_ff <= {hi_y4_ff, {DATA_W{1'b0}}} + NUM_W'(lo_y4_ff);
         n1_x5_ff <= n1_x4_ff;
         n1_y5_ff <= n1_y4_ff;
         dmag5_ff <= dmag4_ff;
         l5_ff    <= l4_ff;
         side5_ff <= side4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign num1_x    = n1_x5_ff;
   assign num1_y    = n1_y5_ff;
   assign num2_x    = n2_x5_ff;
   assign num2_y    = n2_y5_ff;
   assign den_d     = dmag5_ff;
   assign den_l     = l5_ff;
   assign out_side  = side5_ff;

endmodule

// ===== design/fgw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, result clamped to 2^40.
// Depends on fgw_pkg. All stages step only on advance.
module fgw_div import fgw_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [QUO_W-1:0] quo_out
);

   localparam int HI_W = NUM_W - QUO_W;

   logic [DEN_W-1:0] rem_ff [0:QUO_W-1];
   logic [DEN_W-1:0] den_ff [0:QUO_W-1];
   logic [QUO_W-1:0] low_ff [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic             clamp_ff [0:QUO_W];
   logic             clamp_in;

   // quotient of 2^41 or more clamps; else high part is already below den
   assign clamp_in = (DEN_W'(num_in[NUM_W-1:QUO_W]) >= den_in);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]   <= clamp_in ? '0 : DEN_W'(num_in[NUM_W-1:QUO_W]);
         den_ff[0]   <= den_in;
         low_ff[0]   <= num_in[QUO_W-1:0];
         quo_ff[0]   <= '0;
         clamp_ff[0] <= clamp_in;
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      assign trial = {rem_ff[i], low_ff[i][QUO_W-1-i]};
      assign diff  = trial - {1'b0, den_ff[i]};
      assign ge    = (trial >= {1'b0, den_ff[i]});
      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[i+1]   <= {quo_ff[i][QUO_W-2:0], ge};
            clamp_ff[i+1] <= clamp_ff[i];
         end
      end
      // remainder, divisor and dividend bits are not needed past the last step
      if (i < QUO_W-1) begin : g_fwd
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               den_ff[i+1] <= den_ff[i];
               low_ff[i+1] <= low_ff[i];
            end
         end
      end
   end

   assign quo_out = (clamp_ff[QUO_W] || (quo_ff[QUO_W] > CLAMP_MAG)) ? CLAMP_MAG
                                                                    : quo_ff[QUO_W];

endmodule

// ===== design/fgw_back.sv =====
// Back end: signs the quotients, forms g + q1 - q2 for usable walls, saturates, holds the result.
// Other items pass res_x/res_y through. Depends on fgw_pkg.
module fgw_back import fgw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  fgw_side_type     in_side,
   input  logic [QUO_W-1:0] q1_x,
   input  logic [QUO_W-1:0] q1_y,
   input  logic [QUO_W-1:0] q2_x,
   input  logic [QUO_W-1:0] q2_y,
   output logic             out_valid,
   output logic [DATA_W-1:0] out_x,
   output logic [DATA_W-1:0] out_y,
   output logic             out_status
);

   logic                     vb_ff;
   logic signed [TERM_W-1:0] t1_x_ff, t1_y_ff, t2_x_ff, t2_y_ff;
   fgw_side_type             side_ff;

   function automatic logic signed [TERM_W-1:0] apply_sign(logic [QUO_W-1:0] mag,
                                                           logic neg);
      logic signed [TERM_W-1:0] ext;
      ext = $signed({1'b0, mag});
      return neg ? -ext : ext;
   endfunction

   function automatic logic [DATA_W-1:0] sat_sum(logic signed [DATA_W-1:0] g,
                                                 logic signed [TERM_W-1:0] t1,
                                                 logic signed [TERM_W-1:0] t2);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(g) + SUM_W'(t1) - SUM_W'(t2);
      if (s > $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}})))
         return {1'b0, {(DATA_W-1){1'b1}}};
      else if (s < -$signed(SUM_W'({1'b1, {(DATA_W-1){1'b0}}})))
         return {1'b1, {(DATA_W-1){1'b0}}};
      else
         return s[DATA_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_x_ff <= apply_sign(q1_x, in_side.neg1_x);
         t1_y_ff <= apply_sign(q1_y, in_side.neg1_y);
         t2_x_ff <= apply_sign(q2_x, in_side.neg2_x);
         t2_y_ff <= apply_sign(q2_y, in_side.neg2_y);
         side_ff <= in_side;
      end
   end

   logic [DATA_W-1:0] x_ff, y_ff;
   logic              st_ff, vo_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff  <= side_ff.wall_ok ? sat_sum(side_ff.g_x, t1_x_ff, t2_x_ff) : side_ff.res_x;
         y_ff  <= side_ff.wall_ok ? sat_sum(side_ff.g_y, t1_y_ff, t2_y_ff) : side_ff.res_y;
         st_ff <= side_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= in_valid;
         vo_ff <= vb_ff;
      end
   end

   assign out_valid  = vo_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_status = st_ff;

endmodule

// ===== design/face_gradient_wall_correction.sv =====
// Top level of the face gradient with wall normal-derivative correction.
// Depends on fgw_pkg, fgw_front, fgw_div and fgw_back.
//
//   channel | dir | ports                               | payload
//   --------+-----+-------------------------------------+-------------------------
//   req     | in  | req_tvalid req_tready req_tdata/tuser | face geometry and values
//   rsp     | out | rsp_tvalid rsp_tready rsp_tdata/tuser | face gradient and status
//
// One transfer in per cycle while rsp is not blocked, one result per transfer, in order.
// The path runs through five front stages, the 41-step divider plus its
// range-check stage, and two back stages.
// Reset (synchronous) clears only the valid bits along the pipe.
// The pipe moves as one: it holds still only while a result sits at rsp and is
// not taken; req_tready follows that, so nothing is dropped or repeated.
module face_gradient_wall_correction import fgw_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // grad_a_x, grad_a_y, grad_b_x, grad_b_y, normal_x, normal_y,
   // offset_x, offset_y, wall_value, cell_value (32 bits each, low to high)
   input  logic [10*DATA_W-1:0] req_tdata,
   // face_kind
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // face_grad_x, face_grad_y (low to high)
   output logic [2*DATA_W-1:0]  rsp_tdata,
   // status
   output logic                 rsp_tuser
);

   logic advance;

   // whole pipe steps unless the output slot is full and blocked
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic             f_valid;
   logic [NUM_W-1:0] num1_x, num1_y, num2_x, num2_y;
   logic [DEN_W-1:0] den_d, den_l;
   fgw_side_type     f_side;

   fgw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_kind   (req_tuser),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .num1_x    (num1_x),
      .num1_y    (num1_y),
      .num2_x    (num2_x),
      .num2_y    (num2_y),
      .den_d     (den_d),
      .den_l     (den_l),
      .out_side  (f_side)
   );

   logic [QUO_W-1:0] q1_x, q1_y, q2_x, q2_y;

   // delta*n*2^F / (n.o) per component
   fgw_div u_div1x (.clock(clock), .advance(advance), .num_in(num1_x), .den_in(den_d),
                    .quo_out(q1_x));
   fgw_div u_div1y (.clock(clock), .advance(advance), .num_in(num1_y), .den_in(den_d),
                    .quo_out(q1_y));
   // (g.n)*n / (n.n) per component
   fgw_div u_div2x (.clock(clock), .advance(advance), .num_in(num2_x), .den_in(den_l),
                    .quo_out(q2_x));
   fgw_div u_div2y (.clock(clock), .advance(advance), .num_in(num2_y), .den_in(den_l),
                    .quo_out(q2_y));

   // sideband rides alongside the dividers
   fgw_side_type side_ff [0:DIV_LAT-1];
   logic         vld_ff  [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= f_side;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= f_valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   logic [DATA_W-1:0] out_x, out_y;

   fgw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (vld_ff[DIV_LAT-1]),
      .in_side    (side_ff[DIV_LAT-1]),
      .q1_x       (q1_x),
      .q1_y       (q1_y),
      .q2_x       (q2_x),
      .q2_y       (q2_y),
      .out_valid  (rsp_tvalid),
      .out_x      (out_x),
      .out_y      (out_y),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = {out_y, out_x};

   // degenerate wall geometry always reports a zero gradient
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STAT_DEGEN)) |-> (rsp_tdata == '0))
      else $error("degenerate status with nonzero gradient");

   // input is held off while a result waits unclaimed
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output blocked");

   // a wall-ok item never carries the degenerate status into the back end
   a_side_flags: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_LAT-1] |-> !(side_ff[DIV_LAT-1].wall_ok &&
                              (side_ff[DIV_LAT-1].status == STAT_DEGEN)))
      else $error("wall item flagged both usable and degenerate");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ===== tb/sv/face_gradient_wall_correction_tb.sv =====
// Self-checking testbench for face_gradient_wall_correction: stream driver,
// result monitor and an exact-arithmetic face gradient predictor.
// Depends on fgw_pkg and the block's RTL.
`timescale 1ns / 100ps

module face_gradient_wall_correction_tb;
   import fgw_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int LAT  = 49;                    // pipe depth of the block

   typedef struct {
      face_kind_type     kind;
      logic signed [31:0] ax, ay, bx, by, nx, ny, ox, oy, wv, cv;
   } face_item_type;

   typedef struct {
      logic signed [31:0] gx, gy;
      logic               status;
   } face_grad_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // grad_a_x, grad_a_y, grad_b_x, grad_b_y, normal_x, normal_y,
   // offset_x, offset_y, wall_value, cell_value (low to high)
   logic [10*DATA_W-1:0] req_tdata  = '0;
   // face_kind
   logic [1:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // face_grad_x, face_grad_y (low to high)
   logic [2*DATA_W-1:0]  rsp_tdata;
   // status
   logic                 rsp_tuser;

   face_gradient_wall_correction i_dut (.*);

   always #10 clock = ~clock;

   face_item_type face_queue[$];        // faces still to send
   face_grad_type grad_expected[$];     // gradients owed by the block
   face_item_type cur_face;
   int         send_gap  = 0;
   int         recv_stall = 0;
   int         accepted  = 0;
   int         errors    = 0;
   logic       calm      = 1'b0;     // no-idle stretches on both sides
   logic       hold      = 1'b0;     // long receiver hold-off
   int unsigned cycle_cnt = 0;

   // ---------------------------------------------------------------------
   // Predictor: exact wide arithmetic, no square root.
   //   wall component = g + clamp(delta*n*2^F / D) - clamp(G*n / L2), saturated
   // SV signed division truncates toward zero, as the quotients require.
   // ---------------------------------------------------------------------
   function automatic logic signed [127:0] clamp40(logic signed [127:0] q);
      logic signed [127:0] lim;
      lim = 128'sd1 <<< 40;
      if (q > lim) return lim;
      if (q < -lim) return -lim;
      return q;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] wall_component(
         logic signed [127:0] g, logic signed [127:0] n, logic signed [127:0] delta,
         logic signed [127:0] d, logic signed [127:0] gdot, logic signed [127:0] l2);
      logic signed [127:0] q1, q2;
      q1 = clamp40(((delta * n) <<< FRAC) / d);
      q2 = clamp40((gdot * n) / l2);
      return sat32(g + q1 - q2);
   endfunction

   function automatic face_grad_type face_gradient(face_item_type f);
      face_grad_type r;
      logic signed [127:0] ax, ay, bx, by, nx, ny, ox, oy, dist_dot, g_dot, len2, delta;
      ax = f.ax; ay = f.ay; bx = f.bx; by = f.by;
      nx = f.nx; ny = f.ny; ox = f.ox; oy = f.oy;
      r.gx = '0; r.gy = '0; r.status = STAT_OK;
      case (f.kind)
         KIND_INTERIOR: begin
            r.gx = 32'((ax + bx) >>> 1);        // floor of the average
            r.gy = 32'((ay + by) >>> 1);
         end
         KIND_WALL: begin
            dist_dot = nx * ox + ny * oy;
            g_dot    = ax * nx + ay * ny;
            len2     = nx * nx + ny * ny;
            if (len2 == 0 || dist_dot == 0) begin
               r.status = STAT_DEGEN;
            end else begin
               delta = 128'(f.wv) - 128'(f.cv);
               r.gx = wall_component(ax, nx, delta, dist_dot, g_dot, len2);
               r.gy = wall_component(ay, ny, delta, dist_dot, g_dot, len2);
            end
         end
         default: ;                              // other boundary and spare code
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         2:       return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
         3:       return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                             : 32'sh80000000 + $urandom_range(0, 3);
         4:       return $signed($urandom_range(0, 8)) - 32'sd4;
         default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic face_item_type random_face();
      face_item_type f;
      int k;
      k = $urandom_range(0, 19);
      f.kind = k < 7 ? KIND_INTERIOR : k < 17 ? KIND_WALL : k < 19 ? KIND_OTHER : KIND_SPARE;
      f.ax = rand_word(); f.ay = rand_word(); f.bx = rand_word(); f.by = rand_word();
      f.nx = rand_word(); f.ny = rand_word(); f.ox = rand_word(); f.oy = rand_word();
      f.wv = rand_word(); f.cv = rand_word();
      case ($urandom_range(0, 15))
         0: begin f.nx = '0; f.ny = '0; end                  // zero normal
         1: begin f.ox = -f.ny; f.oy = f.nx; end             // offset along face: D = 0
         2: f.wv = f.cv;                                     // adiabatic wall
         3: begin f.ox = f.nx; f.oy = f.ny; end              // offset along normal
         4: f.nx = '0;
         5: f.ny = '0;
         default: ;
      endcase
      return f;
   endfunction

   task automatic add_face(face_kind_type k, logic signed [31:0] ax, ay, bx, by,
                           nx, ny, ox, oy, wv, cv);
      face_item_type f;
      f.kind = k; f.ax = ax; f.ay = ay; f.bx = bx; f.by = by;
      f.nx = nx; f.ny = ny; f.ox = ox; f.oy = oy; f.wv = wv; f.cv = cv;
      face_queue.push_back(f);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents faces from face_queue, random gap after each transfer (none while calm).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      calm      <= (cycle_cnt[9:8] == 2'd3);
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            grad_expected.push_back(face_gradient(cur_face));
            accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (face_queue.size() > 0) begin
               cur_face   = face_queue.pop_front();
               req_tdata  <= {cur_face.cv, cur_face.wv, cur_face.oy, cur_face.ox,
                              cur_face.ny, cur_face.nx, cur_face.by, cur_face.bx,
                              cur_face.ay, cur_face.ax};
               req_tuser  <= cur_face.kind;
               req_tvalid <= 1'b1;
               send_gap   = calm ? 0 : $urandom_range(0, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks every result transfer against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      face_grad_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (grad_expected.size() == 0) begin
               report("unexpected transfer", rsp_tdata[31:0], '0);
            end else begin
               want = grad_expected.pop_front();
               if (rsp_tdata[31:0] !== want.gx)  report("face_grad_x", rsp_tdata[31:0], want.gx);
               if (rsp_tdata[63:32] !== want.gy) report("face_grad_y", rsp_tdata[63:32], want.gy);
               if (rsp_tuser !== want.status)    report("status", rsp_tuser, want.status);
            end
            recv_stall = calm ? 0 : $urandom_range(0, 13);
         end else if (recv_stall > 0) begin
            recv_stall--;
         end
         rsp_tready <= !hold && recv_stall == 0;
      end
   end

   // Long hold-off: the pipe fills and req_tready must drop.
   initial begin
      wait (accepted >= 300);
      @(posedge clock);
      hold <= 1'b1;
      repeat (400) @(posedge clock);
      hold <= 1'b0;
   end

   initial begin
      #5ms;
      $display("face_gradient_wall_correction_tb: errors");
      $finish;
   end

   initial begin
      // directed faces: extremes, floor rounding, every kind, degenerate walls
      add_face(KIND_INTERIOR, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               0, 0, 0, 0, 0, 0);
      add_face(KIND_INTERIOR, -1, 1, 0, 0, 5, 5, 5, 5, 5, 5);
      add_face(KIND_INTERIOR, 32'sh80000000, 3, 32'sh7fffffff, -4, 0, 0, 0, 0, 0, 0);
      add_face(KIND_WALL, 32'sh10000, 32'sh20000, 0, 0, 32'sh10000, 0,
               32'sh8000, 0, 32'sh30000, 32'sh10000);
      add_face(KIND_WALL, 32'sh10000, 32'sh20000, 0, 0, -32'sh10000, 0,
               32'sh8000, 0, 32'sh10000, 32'sh10000);           // flipped normal, adiabatic
      add_face(KIND_WALL, 32'sh50000, -32'sh30000, 0, 0, 32'sh4000, 32'sh4000,
               32'sh2000, -32'sh1000, -32'sh70000, 32'sh20000);
      add_face(KIND_WALL, 1, 2, 3, 4, 0, 0, 32'sh1000, 32'sh1000, 7, 8);      // zero normal
      add_face(KIND_WALL, 1, 2, 3, 4, 32'sh1000, 32'sh2000,
               -32'sh2000, 32'sh1000, 7, 8);                                 // zero distance
      add_face(KIND_WALL, 0, 0, 0, 0, 1, 0, 1, 0,
               32'sh7fffffff, 32'sh80000000);                               // clamp, saturate
      add_face(KIND_WALL, 32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh80000000,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      add_face(KIND_WALL, 32'sh80000000, 32'sh80000000, 0, 0, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0);
      add_face(KIND_WALL, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 1, 1, 1, -1, 1, 0);
      add_face(KIND_OTHER, 32'sh7fffffff, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      add_face(KIND_SPARE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      add_face(KIND_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      repeat (950) face_queue.push_back(random_face());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (face_queue.size() > 0 || req_tvalid || grad_expected.size() > 0);
      repeat (LAT + 10) @(posedge clock);

      if (errors == 0 && grad_expected.size() == 0)
         $display("face_gradient_wall_correction_tb: clean");
      else
         $display("face_gradient_wall_correction_tb: errors");
      $finish;
   end

endmodule
